// ----- hdl/mbq_pkg.sv -----
// Shared types and constants for the modulated biquad low-pass block.
`timescale 1ns / 1ps
package mbq_pkg;

  localparam int ACC_W     = 72;
  localparam int MAC_A_W   = 40;
  localparam int MAC_B_W   = 32;
  localparam int MAC_CNT_W = 6;
  localparam int DIV_W     = 32;

  localparam longint unsigned ONE_Q30    = 64'd1073741824;
  localparam longint unsigned LN2_Q30    = 64'd744261118;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam int UNITY_Q16   = 65536;
  localparam int MAX_FREQ_HZ = 20000;
  localparam int CUT_MIN     = 10;
  localparam int CUT_MAX     = 100;
  localparam int RESET_CUTOFF    = 80;
  localparam int RESET_RESONANCE = 50;

  typedef enum logic [1:0] {
    REG_CUTOFF    = 2'd0,
    REG_RESONANCE = 2'd1,
    REG_MOD_DEPTH = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_ROM, ST_COEF, ST_DIV_START, ST_DIV_WAIT, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_MIX_BASE, OP_MIX_MOD, OP_ENV, OP_ALPHA, OP_B0, OP_B1, OP_B2, OP_A1, OP_A2
  } op_t;

  typedef struct packed {
    logic                 start;
    logic                 clear;
    logic [MAC_CNT_W-1:0] nb;
  } mac_cmd_t;

endpackage

// ----- hdl/mbq_mac.sv -----
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
`timescale 1ns / 1ps
module mbq_mac (
  input  logic                                     clk,
  input  logic                                     rst,
  input  mbq_pkg::mac_cmd_t                        cmd,
  input  logic signed [mbq_pkg::MAC_A_W-1:0]       a,
  input  logic signed [mbq_pkg::MAC_B_W-1:0]       b,
  output logic signed [mbq_pkg::ACC_W-1:0]         acc,
  output logic                                     done
);

  logic signed [mbq_pkg::ACC_W-1:0]   ash;
  logic        [mbq_pkg::MAC_B_W-1:0] bsh;
  logic        [mbq_pkg::MAC_CNT_W-1:0] cnt;
  logic                               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.nb - mbq_pkg::MAC_CNT_W'(1);
        ash  <= mbq_pkg::ACC_W'(a);
        bsh  <= b;
        if (cmd.clear) begin
          acc <= '0;
        end
      end else if (busy) begin
        if (bsh[0]) begin
          // sign bit of the multiplier carries negative weight
          acc <= (cnt == '0) ? acc - ash : acc + ash;
        end
        ash <= ash <<< 1;
        bsh <= bsh >> 1;
        cnt <= cnt - mbq_pkg::MAC_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/mbq_div.sv -----
// Restoring signed divider by a positive divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module mbq_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [mbq_pkg::ACC_W-1:0]     dividend,
  input  logic        [mbq_pkg::DIV_W-1:0]     divisor,
  output logic signed [mbq_pkg::ACC_W-1:0]     quotient,
  output logic                                 done
);

  localparam int CNT_W = $clog2(mbq_pkg::ACC_W);

  logic [mbq_pkg::ACC_W-1:0] dsh;
  logic [mbq_pkg::ACC_W-1:0] quo;
  logic [mbq_pkg::DIV_W:0]   rem;
  logic [mbq_pkg::DIV_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;
  logic                      neg;
  logic                      busy;
  logic [mbq_pkg::DIV_W+1:0] trial;

  assign trial = {rem, dsh[mbq_pkg::ACC_W-1]} - {2'b00, dvs};
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(mbq_pkg::ACC_W - 1);
        neg  <= dividend[mbq_pkg::ACC_W-1];
        dsh  <= dividend[mbq_pkg::ACC_W-1] ? -dividend : dividend;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        if (!trial[mbq_pkg::DIV_W+1]) begin
          rem <= trial[mbq_pkg::DIV_W:0];
          quo <= {quo[mbq_pkg::ACC_W-2:0], 1'b1};
        end else begin
          rem <= {rem[mbq_pkg::DIV_W-1:0], dsh[mbq_pkg::ACC_W-1]};
          quo <= {quo[mbq_pkg::ACC_W-2:0], 1'b0};
        end
        dsh <= dsh << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/modulated_biquad_low_pass.sv -----
// Top level of the modulated biquad low-pass filter.
// Usage:
//   s_axis carries one transaction per audio sample: sample, modulator level and
//   envelope level. m_axis returns one filtered, saturated sample per input.
//   cfg writes cutoff, resonance and modulation depth; write only while idle.
// Datapath:
//   Each sample runs through one bit-serial multiply-accumulate unit (nine
//   products: three of 18 bits, one of 32 bits, five of SAMPLE_BITS+8 bits),
//   then a restoring divider by a0; s_axis_tready is high only between
//   samples, so a new sample is taken only once the last one is through.
//   Coefficient ROMs (sin, cos per cutoff step, 1/(2Q) per resonance) are
//   built at elaboration and read through registers.
// Reset: registers return to cutoff 80, resonance 50, depth 0; filter history
//   clears; no result is pending.
// Stall: a finished result waits in ST_OUT until the output register frees;
//   no new sample is accepted before then.
`timescale 1ns / 1ps
module modulated_biquad_low_pass #(
  parameter int SAMPLE_RATE_HZ   = 48000,
  parameter int CUTOFF_FRAC_BITS = 2,
  parameter int SAMPLE_BITS      = 16,
  localparam int IN_W  = ((SAMPLE_BITS + 32 + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // sample_in, mod_level[14:0], env_level[16:0], zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // sample_out, zero fill
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [16:0]      cfg_data
);

  localparam int STATE_BITS = SAMPLE_BITS + 8;
  localparam int LO_IDX     = mbq_pkg::CUT_MIN << CUTOFF_FRAC_BITS;
  localparam int HI_IDX     = mbq_pkg::CUT_MAX << CUTOFF_FRAC_BITS;
  localparam int TAB_DEPTH  = HI_IDX - LO_IDX + 1;
  localparam int TAB_W      = $clog2(TAB_DEPTH);
  localparam int IDX_W      = $clog2(HI_IDX + 1);
  localparam int RES_DEPTH  = mbq_pkg::CUT_MAX + 1;
  localparam int ENV_SHIFT  = 40 - CUTOFF_FRAC_BITS;
  localparam int CW         = 34;

  typedef logic signed [31:0] sc_tab_t [TAB_DEPTH];
  typedef logic        [31:0] q_tab_t  [RES_DEPTH];

  // shift-subtract long division for the elaboration-time tables
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((num >> i) & 64'd1);
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_q30(longint unsigned t);
    longint unsigned sum;
    longint unsigned term;
    sum  = mbq_pkg::ONE_Q30;
    term = mbq_pkg::ONE_Q30;
    for (int k = 1; k <= 15; k++) begin
      term = udiv((term * t) >> 30, 64'(k));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic longint unsigned pow2_neg(longint unsigned num, longint unsigned den);
    longint unsigned n;
    longint unsigned rm;
    longint unsigned e;
    n  = udiv(num, den);
    rm = num - n * den;
    e  = exp_q30(udiv((den - rm) * mbq_pkg::LN2_Q30, den));
    if (n + 1 > 62) return 0;
    return e >> (n + 1);
  endfunction

  function automatic longint sc_val(longint unsigned turn, bit want_cos);
    longint unsigned a;
    longint unsigned r;
    longint unsigned th;
    longint unsigned th2;
    longint unsigned ts;
    longint unsigned tc;
    longint          s;
    longint          c;
    longint unsigned quad;
    a    = turn & 64'hFFFF_FFFF;
    quad = a >> 30;
    r    = a & 64'h3FFF_FFFF;
    th   = (r * mbq_pkg::TWO_PI_Q30) >> 32;
    th2  = (th * th) >> 30;
    ts   = th;
    tc   = mbq_pkg::ONE_Q30;
    s    = longint'(th);
    c    = longint'(mbq_pkg::ONE_Q30);
    for (int k = 1; k <= 8; k++) begin
      ts = udiv((ts * th2) >> 30, 64'((2 * k) * (2 * k + 1)));
      tc = udiv((tc * th2) >> 30, 64'((2 * k - 1) * (2 * k)));
      if ((k & 1) == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    case (quad)
      0:       return want_cos ? c : s;
      1:       return want_cos ? -s : c;
      2:       return want_cos ? -c : -s;
      default: return want_cos ? s : -c;
    endcase
  endfunction

  function automatic sc_tab_t build_sc(bit want_cos);
    sc_tab_t         tab;
    longint unsigned f;
    longint unsigned turns;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      f = pow2_neg(longint'(HI_IDX - (LO_IDX + i)), longint'(10 << CUTOFF_FRAC_BITS));
      turns = udiv(f * longint'(mbq_pkg::MAX_FREQ_HZ * 4), longint'(SAMPLE_RATE_HZ));
      tab[i] = 32'(sc_val(turns, want_cos));
    end
    return tab;
  endfunction

  function automatic q_tab_t build_q();
    q_tab_t tab;
    for (int i = 0; i < RES_DEPTH; i++) begin
      tab[i] = 32'(pow2_neg(longint'(i + 20), 64'd40));
    end
    return tab;
  endfunction

  localparam sc_tab_t SIN_TAB = build_sc(1'b0);
  localparam sc_tab_t COS_TAB = build_sc(1'b1);
  localparam q_tab_t  INV_TAB = build_q();

  localparam logic signed [mbq_pkg::ACC_W-1:0] ST_HI =
    {{(mbq_pkg::ACC_W - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
  localparam logic signed [mbq_pkg::ACC_W-1:0] ST_LO = ~ST_HI;
  localparam logic signed [STATE_BITS-1:0] SM_HI =
    {{(STATE_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0] SM_LO = ~SM_HI;
  localparam logic signed [CW-1:0] ONE_C = CW'(mbq_pkg::ONE_Q30);

  mbq_pkg::state_t state, state_next;
  mbq_pkg::op_t    op;

  logic [6:0]  cutoff;
  logic [6:0]  resonance;
  logic [16:0] depth;
  logic [6:0]  cp_sat;
  logic [6:0]  rp_sat;
  logic [16:0] d_sat;

  logic signed [SAMPLE_BITS-1:0] x0, prev_in_1, prev_in_2;
  logic signed [STATE_BITS-1:0]  prev_out_1, prev_out_2;
  logic [14:0] ml;
  logic [16:0] env;
  logic [IDX_W-1:0] idx;
  logic signed [31:0] sin_q, cos_q;
  logic        [31:0] inv_q;
  logic signed [31:0] alpha;
  logic        [31:0] a0;
  logic signed [CW-1:0] a2n, b1, b02, c2;
  logic signed [CW-1:0] a0_v;
  logic signed [CW-1:0] b1_v;

  mbq_pkg::mac_cmd_t mac_cmd;
  logic signed [mbq_pkg::MAC_A_W-1:0] mac_a;
  logic signed [mbq_pkg::MAC_B_W-1:0] mac_b;
  logic signed [mbq_pkg::ACC_W-1:0]   mac_acc;
  logic                               mac_done;
  logic                               div_start;
  logic signed [mbq_pkg::ACC_W-1:0]   div_q;
  logic                               div_done;

  logic signed [mbq_pkg::ACC_W-1:0] env_prod;
  logic signed [mbq_pkg::ACC_W-1:0] alpha_v;
  logic signed [STATE_BITS-1:0]     y_state;
  logic signed [SAMPLE_BITS-1:0]    y_out;
  logic                             out_free;

  assign cfg_ready = 1'b1;
  assign cp_sat = (cutoff > 7'(mbq_pkg::CUT_MAX)) ? 7'(mbq_pkg::CUT_MAX) : cutoff;
  assign rp_sat = (resonance > 7'(mbq_pkg::CUT_MAX)) ? 7'(mbq_pkg::CUT_MAX) : resonance;
  assign d_sat  = (depth > 17'(mbq_pkg::UNITY_Q16)) ? 17'(mbq_pkg::UNITY_Q16) : depth;
  assign s_axis_tready = (state == mbq_pkg::ST_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff    <= 7'(mbq_pkg::RESET_CUTOFF);
      resonance <= 7'(mbq_pkg::RESET_RESONANCE);
      depth     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mbq_pkg::REG_CUTOFF:    cutoff    <= cfg_data[6:0];
        mbq_pkg::REG_RESONANCE: resonance <= cfg_data[6:0];
        mbq_pkg::REG_MOD_DEPTH: depth     <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient ROMs, registered read
  always_ff @(posedge clk) begin
    sin_q <= SIN_TAB[TAB_W'(idx - IDX_W'(LO_IDX))];
    cos_q <= COS_TAB[TAB_W'(idx - IDX_W'(LO_IDX))];
    inv_q <= INV_TAB[rp_sat];
  end

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_cmd.start = (state == mbq_pkg::ST_ISSUE);
    mac_cmd.clear = 1'b0;
    mac_cmd.nb    = mbq_pkg::MAC_CNT_W'(18);
    unique case (op)
      mbq_pkg::OP_MIX_BASE: begin
        mac_a = mbq_pkg::MAC_A_W'({cp_sat, 8'd0});
        mac_b = mbq_pkg::MAC_B_W'(18'(mbq_pkg::UNITY_Q16) - {1'b0, d_sat});
        mac_cmd.clear = 1'b1;
      end
      mbq_pkg::OP_MIX_MOD: begin
        mac_a = mbq_pkg::MAC_A_W'(ml);
        mac_b = mbq_pkg::MAC_B_W'(d_sat);
      end
      mbq_pkg::OP_ENV: begin
        mac_a = mac_acc[mbq_pkg::MAC_A_W-1:0];
        mac_b = mbq_pkg::MAC_B_W'(env);
        mac_cmd.clear = 1'b1;
      end
      mbq_pkg::OP_ALPHA: begin
        mac_a = mbq_pkg::MAC_A_W'(sin_q);
        mac_b = inv_q;
        mac_cmd.nb = mbq_pkg::MAC_CNT_W'(32);
        mac_cmd.clear = 1'b1;
      end
      mbq_pkg::OP_B0: begin
        mac_a = mbq_pkg::MAC_A_W'(b02);
        mac_b = mbq_pkg::MAC_B_W'(x0);
        mac_cmd.nb = mbq_pkg::MAC_CNT_W'(STATE_BITS);
        mac_cmd.clear = 1'b1;
      end
      mbq_pkg::OP_B1: begin
        mac_a = mbq_pkg::MAC_A_W'(b1);
        mac_b = mbq_pkg::MAC_B_W'(prev_in_1);
        mac_cmd.nb = mbq_pkg::MAC_CNT_W'(STATE_BITS);
      end
      mbq_pkg::OP_B2: begin
        mac_a = mbq_pkg::MAC_A_W'(b02);
        mac_b = mbq_pkg::MAC_B_W'(prev_in_2);
        mac_cmd.nb = mbq_pkg::MAC_CNT_W'(STATE_BITS);
      end
      mbq_pkg::OP_A1: begin
        mac_a = mbq_pkg::MAC_A_W'(c2);
        mac_b = mbq_pkg::MAC_B_W'(prev_out_1);
        mac_cmd.nb = mbq_pkg::MAC_CNT_W'(STATE_BITS);
      end
      mbq_pkg::OP_A2: begin
        mac_a = mbq_pkg::MAC_A_W'(a2n);
        mac_b = mbq_pkg::MAC_B_W'(prev_out_2);
        mac_cmd.nb = mbq_pkg::MAC_CNT_W'(STATE_BITS);
      end
      default: ;
    endcase
  end

  mbq_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (mac_acc),
    .done (mac_done)
  );

  assign div_start = (state == mbq_pkg::ST_DIV_START);

  mbq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mac_acc),
    .divisor  (a0),
    .quotient (div_q),
    .done     (div_done)
  );

  assign env_prod = mac_acc >>> ENV_SHIFT;
  assign alpha_v  = mac_acc[mbq_pkg::ACC_W-1]
                  ? (mac_acc + mbq_pkg::ACC_W'(mbq_pkg::ONE_Q30 - 1)) >>> 30
                  : mac_acc >>> 30;
  assign a0_v     = ONE_C + CW'(alpha);
  assign b1_v     = ONE_C - CW'(cos_q);

  assign y_state = (div_q > ST_HI) ? ST_HI[STATE_BITS-1:0]
                 : (div_q < ST_LO) ? ST_LO[STATE_BITS-1:0]
                 : div_q[STATE_BITS-1:0];
  assign y_out   = (y_state > SM_HI) ? SM_HI[SAMPLE_BITS-1:0]
                 : (y_state < SM_LO) ? SM_LO[SAMPLE_BITS-1:0]
                 : y_state[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mbq_pkg::ST_IDLE:      if (s_axis_tvalid) state_next = mbq_pkg::ST_ISSUE;
      mbq_pkg::ST_ISSUE:     state_next = mbq_pkg::ST_WAIT;
      mbq_pkg::ST_WAIT: begin
        if (mac_done) begin
          unique case (op)
            mbq_pkg::OP_ENV:   state_next = mbq_pkg::ST_ROM;
            mbq_pkg::OP_ALPHA: state_next = mbq_pkg::ST_COEF;
            mbq_pkg::OP_A2:    state_next = mbq_pkg::ST_DIV_START;
            default:           state_next = mbq_pkg::ST_ISSUE;
          endcase
        end
      end
      mbq_pkg::ST_ROM:       state_next = mbq_pkg::ST_ISSUE;
      mbq_pkg::ST_COEF:      state_next = mbq_pkg::ST_ISSUE;
      mbq_pkg::ST_DIV_START: state_next = mbq_pkg::ST_DIV_WAIT;
      mbq_pkg::ST_DIV_WAIT:  if (div_done) state_next = mbq_pkg::ST_OUT;
      mbq_pkg::ST_OUT:       if (out_free) state_next = mbq_pkg::ST_IDLE;
      default:               state_next = mbq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op            <= mbq_pkg::OP_MIX_BASE;
      m_axis_tvalid <= 1'b0;
      prev_in_1     <= '0;
      prev_in_2     <= '0;
      prev_out_1    <= '0;
      prev_out_2    <= '0;
    end else begin
      if (m_axis_tready && state != mbq_pkg::ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        mbq_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            op  <= mbq_pkg::OP_MIX_BASE;
            x0  <= s_axis_tdata[SAMPLE_BITS-1:0];
            ml  <= s_axis_tdata[SAMPLE_BITS+14:SAMPLE_BITS];
            env <= (s_axis_tdata[SAMPLE_BITS+31:SAMPLE_BITS+15] > 17'(mbq_pkg::UNITY_Q16))
                 ? 17'(mbq_pkg::UNITY_Q16) : s_axis_tdata[SAMPLE_BITS+31:SAMPLE_BITS+15];
          end
        end
        mbq_pkg::ST_WAIT: begin
          if (mac_done) begin
            case (op)
              mbq_pkg::OP_ENV: begin
                if (env_prod < mbq_pkg::ACC_W'(LO_IDX)) begin
                  idx <= IDX_W'(LO_IDX);
                end else if (env_prod > mbq_pkg::ACC_W'(HI_IDX)) begin
                  idx <= IDX_W'(HI_IDX);
                end else begin
                  idx <= env_prod[IDX_W-1:0];
                end
              end
              mbq_pkg::OP_ALPHA: alpha <= alpha_v[31:0];
              mbq_pkg::OP_A2: ;
              default: op <= mbq_pkg::op_t'(op + 4'd1);
            endcase
          end
        end
        mbq_pkg::ST_ROM: op <= mbq_pkg::OP_ALPHA;
        mbq_pkg::ST_COEF: begin
          op  <= mbq_pkg::OP_B0;
          a0  <= (a0_v <= 0) ? 32'd1 : a0_v[31:0];
          a2n <= CW'(alpha) - ONE_C;
          b1  <= b1_v;
          // halve rounding toward zero
          b02 <= $signed(b1_v + CW'(b1_v[CW-1])) >>> 1;
          c2  <= CW'(cos_q) <<< 1;
        end
        mbq_pkg::ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_W'({{(OUT_W - SAMPLE_BITS){1'b0}}, y_out});
            prev_in_2     <= prev_in_1;
            prev_in_1     <= x0;
            prev_out_2    <= prev_out_1;
            prev_out_1    <= y_state;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");
  a_mac_done_state: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == mbq_pkg::ST_WAIT))
    else $error("multiplier finished outside its wait state");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == mbq_pkg::ST_DIV_WAIT))
    else $error("divider finished outside its wait state");
`endif

endmodule

// ----- dv/mbq_checker.sv -----
// Checker for the modulated biquad low-pass filter: predicts and compares each output sample.
`timescale 1ns / 1ps
module mbq_checker
  import mbq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          fail_count
);

  localparam longint unsigned RATE_HZ = 48000;
  localparam int              FRAC    = 2;

  logic [6:0]         cutoff_reg;
  logic [6:0]         res_reg;
  logic [16:0]        depth_reg;
  longint             x_d1, x_d2, y_d1, y_d2;
  logic signed [15:0] sample_q[$];

  function automatic longint sat(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned exp_fix(longint unsigned t);
    longint unsigned sum, term;
    sum  = ONE_Q30;
    term = ONE_Q30;
    for (int k = 1; k <= 15; k++) begin
      term = ((term * t) >> 30) / k;
      sum += term;
    end
    return sum;
  endfunction

  function automatic longint unsigned exp2_neg(longint unsigned num, longint unsigned den);
    longint unsigned n, rem, e;
    n   = num / den;
    rem = num % den;
    e   = exp_fix(((den - rem) * LN2_Q30) / den);
    if (n + 1 > 62) return 0;
    return e >> (n + 1);
  endfunction

  function automatic void sin_cos(input longint unsigned turn, output longint so,
                                  output longint co);
    longint unsigned a, r, th, th2, ts, tc;
    longint          s, c;
    a   = turn & 64'hFFFF_FFFF;
    r   = a & 64'h3FFF_FFFF;
    th  = (r * TWO_PI_Q30) >> 32;
    th2 = (th * th) >> 30;
    ts  = th;
    tc  = ONE_Q30;
    s   = longint'(th);
    c   = longint'(ONE_Q30);
    for (int k = 1; k <= 8; k++) begin
      ts = ((ts * th2) >> 30) / ((2 * k) * (2 * k + 1));
      tc = ((tc * th2) >> 30) / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
    case (a >> 30)
      0: begin so = s;  co = c;  end
      1: begin so = c;  co = -s; end
      2: begin so = -s; co = -c; end
      default: begin so = -c; co = s; end
    endcase
  endfunction

  function automatic logic signed [15:0] filter_sample(logic [47:0] word);
    longint          x0, s, c, alpha, a0, a2, b1, b02, acc, y;
    longint unsigned ml, env, cp, rp, d, mix, idx, lo, hi, f, turn, inv2q;
    x0    = longint'($signed(word[15:0]));
    ml    = word[30:16];
    env   = word[47:31];
    cp    = (cutoff_reg > CUT_MAX) ? CUT_MAX : cutoff_reg;
    rp    = (res_reg > CUT_MAX) ? CUT_MAX : res_reg;
    d     = (depth_reg > UNITY_Q16) ? UNITY_Q16 : depth_reg;
    if (env > UNITY_Q16) env = UNITY_Q16;
    mix   = cp * 256 * (UNITY_Q16 - d) + ml * d;
    idx   = (mix * env) >> (40 - FRAC);
    lo    = longint'(CUT_MIN) << FRAC;
    hi    = longint'(CUT_MAX) << FRAC;
    if (idx < lo) idx = lo;
    if (idx > hi) idx = hi;
    f     = exp2_neg(hi - idx, longint'(10) << FRAC);
    turn  = (f * MAX_FREQ_HZ * 4) / RATE_HZ;
    sin_cos(turn, s, c);
    inv2q = exp2_neg(rp + 20, 40);
    alpha = (s * longint'(inv2q)) / longint'(ONE_Q30);
    a0    = longint'(ONE_Q30) + alpha;
    a2    = longint'(ONE_Q30) - alpha;
    b1    = longint'(ONE_Q30) - c;
    b02   = b1 / 2;
    if (a0 <= 0) a0 = 1;
    acc   = b02 * x0 + b1 * x_d1 + b02 * x_d2 + 2 * c * y_d1 - a2 * y_d2;
    y     = sat(acc / a0, 24);
    x_d2  = x_d1;
    x_d1  = x0;
    y_d2  = y_d1;
    y_d1  = y;
    return 16'(sat(y, 16));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cutoff_reg <= 7'(RESET_CUTOFF);
      res_reg    <= 7'(RESET_RESONANCE);
      depth_reg  <= '0;
      x_d1 = 0; x_d2 = 0; y_d1 = 0; y_d2 = 0;
      sample_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CUTOFF:    cutoff_reg <= cfg_data[6:0];
          REG_RESONANCE: res_reg    <= cfg_data[6:0];
          REG_MOD_DEPTH: depth_reg  <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        sample_q.push_back(filter_sample(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (sample_q.size() == 0) begin
          $display("%0t unexpected output sample %0d", $time, $signed(m_axis_tdata));
          fail_count <= fail_count + 1;
        end else begin
          if ($signed(m_axis_tdata) !== sample_q[0]) begin
            $display("%0t sample_out expected %0d got %0d", $time, sample_q[0],
                     $signed(m_axis_tdata));
            fail_count <= fail_count + 1;
          end
          void'(sample_q.pop_front());
        end
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the modulated biquad low-pass filter: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
  import mbq_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         SETTLE     = 400;
  localparam longint     CYCLE_CAP  = 2000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  int          fail_count;
  int          sent_cnt = 0;
  int          recv_cnt = 0;
  longint      cycles = 0;
  bit          hold_req = 0;
  bit          gaps_on = 1;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  modulated_biquad_low_pass u_dut (.*);

  mbq_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (s_axis_tvalid && s_axis_tready) sent_cnt <= sent_cnt + 1;
    if (m_axis_tvalid && m_axis_tready) recv_cnt <= recv_cnt + 1;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // output side: random backpressure, one long hold on request
  initial begin
    int g;
    @(posedge clk iff !rst);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          m_axis_tready <= 0;
          repeat (g) @(posedge clk);
        end
        m_axis_tready <= 1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send(logic [15:0] smp, logic [14:0] ml, logic [16:0] env);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {env, ml, smp};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (recv_cnt != sent_cnt) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [16:0] cp, logic [16:0] rp, logic [16:0] md);
    write_reg(REG_CUTOFF, cp);
    write_reg(REG_RESONANCE, rp);
    write_reg(REG_MOD_DEPTH, md);
  endtask

  task automatic random_items(int n);
    logic [15:0] smp;
    logic [14:0] ml;
    logic [16:0] env;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        1: smp = 16'($signed($urandom_range(2000)) - 1000);
        default: smp = 16'($urandom);
      endcase
      ml  = ($urandom_range(4) == 0) ? 15'($urandom) : 15'($urandom_range(25600));
      case ($urandom_range(7))
        0: env = 17'($urandom);
        1: env = 17'd65536;
        default: env = 17'($urandom_range(65536));
      endcase
      send(smp, ml, env);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings first
    send(16'h7FFF, 15'd0, 17'd65536);
    send(16'h8000, 15'd0, 17'd65536);
    send(16'h0000, 15'd0, 17'd65536);
    send(16'h7FFF, 15'd0, 17'd0);
    send(16'h7FFF, 15'd0, 17'h1FFFF);
    drain();

    set_regs(17'd100, 17'd100, 17'd65536);
    send(16'h7FFF, 15'd25600, 17'd65536);
    send(16'h8000, 15'h7FFF, 17'd65536);
    send(16'h7FFF, 15'd0, 17'd65536);
    send(16'h8000, 15'd2560, 17'h1FFFF);
    send(16'h7FFF, 15'd25600, 17'd0);
    drain();

    set_regs(17'd127, 17'd127, 17'h1FFFF);
    send(16'h8000, 15'h7FFF, 17'h1FFFF);
    send(16'h7FFF, 15'h5555, 17'h0AAAA);
    send(16'h5555, 15'h2AAA, 17'h15555);
    drain();

    set_regs(17'd0, 17'd0, 17'd32768);
    write_reg(REG_UNUSED, 17'h1FFFF);
    send(16'h7FFF, 15'd12800, 17'd65536);
    send(16'h8000, 15'd0, 17'd65536);
    send(16'hAAAA, 15'h7FFF, 17'd40000);
    send(16'h7FFF, 15'd25600, 17'd65536);
    drain();

    set_regs(17'd80, 17'd50, 17'd0);
    random_items(120);
    drain();

    set_regs(17'd10, 17'd0, 17'd65536);
    gaps_on = 0;
    random_items(100);
    drain();
    gaps_on = 1;

    set_regs(17'd100, 17'd100, 17'd20000);
    random_items(40);
    hold_req = 1;
    random_items(80);
    drain();

    set_regs(17'd0, 17'd127, 17'h1FFFF);
    random_items(100);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_regs(17'($urandom_range(127)), 17'($urandom_range(127)), 17'($urandom));
      random_items(90);
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
